>>> sv/bmap_pkg.sv
// ----------------------------------------------------------------------------
// bmap_pkg
// Shared types and constants of the bump map shader: geometry limits,
// register indexes, reset values and the structs passed between stages.
// ----------------------------------------------------------------------------
package bmap_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int DIM_W   = 11;  // geometry register width
  localparam int LIGHT_W = 9;
  localparam int PIX_W   = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // signed width that holds sample - sample + light - coordinate exactly
  localparam int NRM_W = ((COL_W > ROW_W ? COL_W : ROW_W) > LIGHT_W ?
                          (COL_W > ROW_W ? COL_W : ROW_W) : LIGHT_W) + 3;

  localparam int SQRT_STEPS = 8;
  localparam int SPOT_CUT   = 64516;  // 254*254: at or above, shade is zero

  localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = 11'd340;
  localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = 11'd360;
  localparam logic [LIGHT_W-1:0] RST_LIGHT_X      = 9'd256;
  localparam logic [LIGHT_W-1:0] RST_LIGHT_Y      = 9'd336;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_LIGHT_X      = 2'd2,
    REG_LIGHT_Y      = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
    logic [LIGHT_W-1:0] light_x;
    logic [LIGHT_W-1:0] light_y;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } pix_tag_t;

  typedef struct packed {
    logic             valid;
    pix_tag_t         tag;
    logic [PIX_W-1:0] nx;
    logic [PIX_W-1:0] ny;
  } norm_t;

endpackage

>>> sv/bmap_front.sv
// ----------------------------------------------------------------------------
// bmap_front
// Raster position counters, the previous-row line store and the gradient /
// normal stage. Each accepted sample reads and rewrites its column entry.
// ----------------------------------------------------------------------------
module bmap_front
  import bmap_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  input  logic [PIX_W-1:0] sample_i,
  input  logic             adv_i,
  output norm_t            norm_o
);

  logic [PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [PIX_W-1:0] up_left_q;   // read port register, holds h(col-1,row-1)
  logic [PIX_W-1:0] left_q;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  logic             accept;
  logic [COL_W:0]   w, cext, col_inc;
  logic [ROW_W:0]   h, rext, row_inc;
  logic             interior;
  logic [COL_W-1:0] x;
  logic signed [NRM_W-1:0] nx_s, ny_s;
  logic [PIX_W-1:0] nx, ny;
  logic             valid_q;
  pix_tag_t         tag_q;
  logic [PIX_W-1:0] nx_q, ny_q;

  assign accept = in_valid_i & adv_i;

  always_comb begin
    if (cfg_i.frame_width < DIM_W'(3)) begin
      w = (COL_W+1)'(3);
    end else if (int'(cfg_i.frame_width) > MAX_WIDTH) begin
      w = (COL_W+1)'(MAX_WIDTH);
    end else begin
      w = (COL_W+1)'(cfg_i.frame_width);
    end
    if (cfg_i.frame_height < DIM_W'(3)) begin
      h = (ROW_W+1)'(3);
    end else if (int'(cfg_i.frame_height) > MAX_HEIGHT) begin
      h = (ROW_W+1)'(MAX_HEIGHT);
    end else begin
      h = (ROW_W+1)'(cfg_i.frame_height);
    end
  end

  always_comb begin
    cext     = {1'b0, col_q};
    rext     = {1'b0, row_q};
    interior = (cext >= (COL_W+1)'(2)) && (cext <= w - 1'b1) &&
               (rext >= (ROW_W+1)'(1)) && (rext <= h - (ROW_W+1)'(2));
    col_inc  = cext + 1'b1;
    row_inc  = rext + 1'b1;
    if (col_inc >= w) begin
      col_d = '0;
      row_d = (row_inc >= h) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_d = col_inc[COL_W-1:0];
      row_d = (rext >= h) ? '0 : row_q;
    end
  end

  // the pixel shaded is one column left of the incoming sample
  assign x = col_q - 1'b1;

  always_comb begin
    nx_s = NRM_W'(sample_i) - NRM_W'(left_q) + NRM_W'(cfg_i.light_x) - NRM_W'(x);
    ny_s = NRM_W'(left_q) - NRM_W'(up_left_q) + NRM_W'(cfg_i.light_y) - NRM_W'(row_q);
    nx   = (nx_s < 0 || nx_s > 255) ? '0 : nx_s[PIX_W-1:0];
    ny   = (ny_s < 0 || ny_s > 255) ? '0 : ny_s[PIX_W-1:0];
  end

  // read-first: the old row entry comes out while the new sample goes in
  always_ff @(posedge clk_i) begin
    if (accept) begin
      up_left_q      <= line_mem[col_q];
      line_mem[col_q] <= sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else if (accept) begin
      left_q <= sample_i;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= accept & interior;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tag_q.col  <= x;
      tag_q.row  <= row_q;
      tag_q.last <= (cext == w - 1'b1) && (rext == h - (ROW_W+1)'(2));
      nx_q       <= nx;
      ny_q       <= ny;
    end
  end

  assign norm_o.valid = valid_q;
  assign norm_o.tag   = tag_q;
  assign norm_o.nx    = nx_q;
  assign norm_o.ny    = ny_q;

`ifndef SYNTHESIS
  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cext == w - 1'b1) |=> (col_q == '0))
    else $error("column count did not wrap at end of row");

  a_interior_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (tag_q.col != '0 && tag_q.row != '0))
    else $error("border pixel marked for shading");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && !accept) |=> !valid_q)
    else $error("result issued without an input transfer");
`endif

endmodule

>>> sv/bmap_spot.sv
// ----------------------------------------------------------------------------
// bmap_spot
// Reflection spot pipeline: squared distance, scaling, pipelined integer
// square root (one root bit per stage) and the output register.
// ----------------------------------------------------------------------------
module bmap_spot
  import bmap_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  norm_t            norm_i,
  input  logic             out_ready_i,
  output logic             adv_o,
  output logic             out_valid_o,
  output logic [PIX_W-1:0] shade_o,
  output pix_tag_t         tag_o
);

  logic signed [15:0]    ax, ay;
  logic [15:0]           d_n;
  logic                  a_valid_q, b_valid_q, c_valid_q;
  pix_tag_t              a_tag_q, b_tag_q, c_tag_q;
  logic [15:0]           a_d_q;
  logic [30:0]           b_tgt_q;
  logic [30:0]           tgt_m1;
  logic [16:0]           rad17;
  logic [15:0]           c_rad_q;
  logic                  c_zero_q, c_over_q;

  logic                  sq_valid_q [SQRT_STEPS];
  pix_tag_t              sq_tag_q   [SQRT_STEPS];
  logic [15:0]           sq_rad_q   [SQRT_STEPS];
  logic [7:0]            sq_root_q  [SQRT_STEPS];
  logic [7:0]            root_n     [SQRT_STEPS];
  logic                  sq_zero_q  [SQRT_STEPS];
  logic                  sq_over_q  [SQRT_STEPS];

  logic                  out_valid_q;
  logic [PIX_W-1:0]      shade_q;
  pix_tag_t              tag_q;
  logic [PIX_W-1:0]      shade_n;

  function automatic logic [7:0] sqrt_step(input logic [7:0] root,
                                           input logic [15:0] rad,
                                           input logic [2:0] bitpos);
    logic [7:0]  cand;
    logic [15:0] sq;
    cand = root | (8'd1 << bitpos);
    sq   = 16'(cand) * 16'(cand);
    return (sq <= rad) ? cand : root;
  endfunction

  // whole pipeline holds while the output register waits
  assign adv_o = !out_valid_q || out_ready_i;

  always_comb begin
    ax  = 16'($signed({1'b0, norm_i.nx})) - 16'sd128;
    ay  = 16'($signed({1'b0, norm_i.ny})) - 16'sd128;
    d_n = 16'(ax * ax) + 16'(ay * ay);
  end

  // k = ceil(sqrt(T)/128) = floor(sqrt((T-1)>>14)) + 1 for T > 0
  always_comb begin
    tgt_m1 = b_tgt_q - 1'b1;
    rad17  = 17'(tgt_m1 >> 14);
  end

  always_comb begin
    root_n[0] = sqrt_step(8'd0, c_rad_q, 3'd7);
    for (int j = 1; j < SQRT_STEPS; j++) begin
      root_n[j] = sqrt_step(sq_root_q[j-1], sq_rad_q[j-1], 3'(SQRT_STEPS - 1 - j));
    end
  end

  always_comb begin
    if (sq_over_q[SQRT_STEPS-1]) begin
      shade_n = '0;
    end else if (sq_zero_q[SQRT_STEPS-1]) begin
      shade_n = 8'd255;
    end else begin
      shade_n = 8'd254 - sq_root_q[SQRT_STEPS-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < SQRT_STEPS; j++) begin
        sq_valid_q[j] <= 1'b0;
      end
    end else if (adv_o) begin
      a_valid_q     <= norm_i.valid;
      b_valid_q     <= a_valid_q;
      c_valid_q     <= b_valid_q;
      sq_valid_q[0] <= c_valid_q;
      for (int j = 1; j < SQRT_STEPS; j++) begin
        sq_valid_q[j] <= sq_valid_q[j-1];
      end
      out_valid_q   <= sq_valid_q[SQRT_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      a_tag_q  <= norm_i.tag;
      a_d_q    <= d_n;
      b_tag_q  <= a_tag_q;
      b_tgt_q  <= 31'(32'(a_d_q) * 32'd65025);
      c_tag_q  <= b_tag_q;
      c_rad_q  <= rad17[15:0];
      c_zero_q <= (b_tgt_q == '0);
      c_over_q <= (b_tgt_q != '0) && (rad17 >= 17'(SPOT_CUT));
      sq_tag_q[0]  <= c_tag_q;
      sq_rad_q[0]  <= c_rad_q;
      sq_root_q[0] <= root_n[0];
      sq_zero_q[0] <= c_zero_q;
      sq_over_q[0] <= c_over_q;
      for (int j = 1; j < SQRT_STEPS; j++) begin
        sq_tag_q[j]  <= sq_tag_q[j-1];
        sq_rad_q[j]  <= sq_rad_q[j-1];
        sq_root_q[j] <= root_n[j];
        sq_zero_q[j] <= sq_zero_q[j-1];
        sq_over_q[j] <= sq_over_q[j-1];
      end
      shade_q <= shade_n;
      tag_q   <= sq_tag_q[SQRT_STEPS-1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign shade_o     = shade_q;
  assign tag_o       = tag_q;

`ifndef SYNTHESIS
  a_root_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_valid_q[SQRT_STEPS-1] && !sq_over_q[SQRT_STEPS-1]) |->
    (18'(sq_root_q[SQRT_STEPS-1]) * 18'(sq_root_q[SQRT_STEPS-1]) <=
     18'(sq_rad_q[SQRT_STEPS-1])))
    else $error("square root too large");

  a_root_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_valid_q[SQRT_STEPS-1] && !sq_over_q[SQRT_STEPS-1]) |->
    ((18'(sq_root_q[SQRT_STEPS-1]) + 18'd1) * (18'(sq_root_q[SQRT_STEPS-1]) + 18'd1) >
     18'(sq_rad_q[SQRT_STEPS-1])))
    else $error("square root too small");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q |-> !(c_zero_q && c_over_q))
    else $error("zero distance flagged as outside the spot");
`endif

endmodule

>>> sv/bump_map_2d_shader.sv
// ----------------------------------------------------------------------------
// bump_map_2d_shader
// Bump mapped shading of a height image streamed in raster order.
//
//   channel   dir  handshake              payload
//   s_axis    in   tvalid/tready          tdata[7:0] height_sample
//   m_axis    out  tvalid/tready          tdata: shade, pixel_col, pixel_row;
//                                         tlast: frame_end
//   cfg       in   cfg_we_i (no stall)    cfg_idx_i, cfg_wdata_i
//
// One sample per clock while m_axis takes results. A pixel's result is
// formed when the sample to its right is taken, then runs through bmap_spot.
// The line store is a single read-first port: each sample reads and rewrites
// its column entry in the cycle it is taken.
// When the output register is full and not taken, the whole pipe holds and
// s_axis_tready drops. No clearing pass after reset; the line store is
// undefined until the first row has been written.
// ----------------------------------------------------------------------------
module bump_map_2d_shader
  import bmap_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] height_sample
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,   // [7:0] shade, [17:8] pixel_col,
                                                // [27:18] pixel_row, [31:28] zero
  output logic                  m_axis_tlast    // frame_end
);

  cfg_t             cfg_q;
  norm_t            norm;
  logic             adv;
  logic [PIX_W-1:0] shade;
  pix_tag_t         tag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= RST_FRAME_WIDTH;
      cfg_q.frame_height <= RST_FRAME_HEIGHT;
      cfg_q.light_x      <= RST_LIGHT_X;
      cfg_q.light_y      <= RST_LIGHT_Y;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_wdata_i;
        REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_wdata_i;
        REG_LIGHT_X:      cfg_q.light_x      <= cfg_wdata_i[LIGHT_W-1:0];
        REG_LIGHT_Y:      cfg_q.light_y      <= cfg_wdata_i[LIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  bmap_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .sample_i   (s_axis_tdata),
    .adv_i      (adv),
    .norm_o     (norm)
  );

  bmap_spot u_spot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .norm_i      (norm),
    .out_ready_i (m_axis_tready),
    .adv_o       (adv),
    .out_valid_o (m_axis_tvalid),
    .shade_o     (shade),
    .tag_o       (tag)
  );

  assign s_axis_tready = adv;
  assign m_axis_tdata  = {4'b0000, 10'(tag.row), 10'(tag.col), shade};
  assign m_axis_tlast  = tag.last;

endmodule
